>>> hw/rtl/atgc_pkg.sv
// Shared types and constants of the audio timestamp gap corrector.
// No dependencies; the engine, the core and the testbench refer to this package by scoped names.
package atgc_pkg;

  localparam int unsigned TimeW   = 63;
  localparam int unsigned LenW    = 24;
  localparam int unsigned RateW   = 19;
  localparam int unsigned FrameW  = 7;
  localparam int unsigned ThrW    = 27;
  localparam int unsigned ChunkW  = 21;
  localparam int unsigned CfgW    = 27;
  localparam int unsigned CarryW  = 12;

  // 100 ns ticks in one second
  localparam logic [23:0] TicksPerSec = 24'd10000000;
  localparam logic [RateW-1:0] MinRate = 19'd8000;
  // largest sub-frame remainder: period is at most 10^7 / 8000
  localparam logic signed [CarryW-1:0] MaxCarry = 12'sd1249;

  typedef enum logic [1:0] {
    CFG_SAMPLE_RATE,
    CFG_FRAME_BYTES,
    CFG_GAP_THRESHOLD,
    CFG_CHUNK_BYTES
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_SILENCE,
    KIND_TRIM,
    KIND_DROP
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PER,
    ST_LEN,
    ST_CHK,
    ST_CLASS,
    ST_CORR,
    ST_GAP,
    ST_SIL,
    ST_SILW,
    ST_PASS,
    ST_PASSW,
    ST_TRIM,
    ST_TRIM2,
    ST_TRIMW
  } state_e;

  typedef struct packed {
    logic [RateW-1:0]  sample_rate;
    logic [FrameW-1:0] frame_bytes;
    logic [ThrW-1:0]   gap_threshold;
    logic [ChunkW-1:0] chunk_bytes;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] start_time;
    logic             time_valid;
    logic [LenW-1:0]  length_bytes;
  } item_t;

  typedef struct packed {
    kind_e            kind;
    logic [TimeW-1:0] out_start;
    logic [TimeW-1:0] out_stop;
    logic [LenW-1:0]  out_bytes;
    logic [LenW-1:0]  skip_bytes;
    logic             last;
  } result_t;

endpackage

>>> hw/rtl/atgc_fifo.sv
// Small register queue with push/full and pop/empty handshakes.
// Used for the input side, the result side of the gap corrector.
module atgc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/atgc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Quotient and remainder hold after completion until the next start.
module atgc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [18:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] quotient_o,
  output logic [18:0] remainder_o
);

  logic        busy_q, busy_d;
  logic [5:0]  step_q, step_d;
  logic [63:0] dvd_q, dvd_d;
  logic [18:0] dsr_q, dsr_d;
  logic [18:0] rem_q, rem_d;
  logic [19:0] shifted;
  logic [20:0] diff;

  assign shifted     = {rem_q, dvd_q[63]};
  assign diff        = {1'b0, shifted} - {2'b00, dsr_q};
  assign busy_o      = busy_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (!diff[20]) begin
        rem_d = diff[18:0];
      end else begin
        rem_d = shifted[18:0];
      end
      dvd_d  = {dvd_q[62:0], ~diff[20]};
      step_d = step_q + 6'd1;
      if (step_q == 6'd63) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

endmodule

>>> hw/rtl/atgc_engine.sv
// Back end of the gap corrector: timeline state, gap test, silence and trim
// sequencing over one shared divider. Depends on atgc_pkg and atgc_div.
module atgc_engine #(
  parameter int unsigned MaxSilenceChunks = 63
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  atgc_pkg::cfg_t    cfg_i,
  input  logic              in_empty_i,
  output logic              in_pop_o,
  input  atgc_pkg::item_t   in_item_i,
  input  logic              res_full_i,
  output logic              res_push_o,
  output atgc_pkg::result_t res_o
);

  localparam int unsigned CntW = $clog2(MaxSilenceChunks + 1);

  atgc_pkg::state_e state_q, state_d;
  atgc_pkg::item_t  item_q, item_d;
  logic [63:0]      exp_q, exp_d;
  logic signed [atgc_pkg::CarryW-1:0] carry_q, carry_d;
  logic             started_q, started_d;
  logic [10:0]      period_q, period_d;
  logic [23:0]      lenf_q, lenf_d;
  logic [20:0]      chunkf_q, chunkf_d;
  logic [63:0]      gap_q, gap_d;
  logic [31:0]      frl_q, frl_d;
  logic [20:0]      nf_q, nf_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [38:0]      gb_q, gb_d;
  logic [63:0]      nstart_q, nstart_d;

  logic        div_start, div_busy;
  logic [63:0] div_dvd, div_quo;
  logic [18:0] div_dsr, div_rem;

  logic [18:0] rate_eff;
  logic [6:0]  fb_eff;
  logic [20:0] chunk_eff;
  logic [63:0] start_sx, exp_base, gap_raw, mag_raw, mag_corr, carry_sx, nstop;
  logic [20:0] nf_next;
  logic [23:0] mul_a;
  logic [47:0] mul_prod;
  logic [27:0] sil_prod;
  logic [38:0] gb_prod;
  logic [10:0] rem11;

  // effective configuration
  assign rate_eff  = (cfg_i.sample_rate < atgc_pkg::MinRate) ? atgc_pkg::MinRate
                                                              : cfg_i.sample_rate;
  assign fb_eff    = (cfg_i.frame_bytes == '0) ? 7'd1 : cfg_i.frame_bytes;
  assign chunk_eff = (cfg_i.chunk_bytes < 21'(fb_eff)) ? 21'(fb_eff) : cfg_i.chunk_bytes;

  // timeline arithmetic
  assign start_sx = {item_q.start_time[62], item_q.start_time};
  assign exp_base = started_q ? exp_q : start_sx;
  assign gap_raw  = start_sx - exp_base;
  assign mag_raw  = gap_raw[63] ? (64'd0 - gap_raw) : gap_raw;
  assign carry_sx = 64'(signed'(carry_q));
  assign mag_corr = gap_q[63] ? (64'd0 - gap_q) : gap_q;
  assign nf_next  = (32'(chunkf_q) < frl_q) ? chunkf_q : frl_q[20:0];
  assign sil_prod = 28'(nf_q) * 28'(fb_eff);
  assign gb_prod  = 39'(frl_q) * 39'(fb_eff);
  assign nstop    = nstart_q + div_quo;
  assign rem11    = div_rem[10:0];

  // frame count fed to the duration divide
  always_comb begin
    unique case (state_q)
      atgc_pkg::ST_SIL:   mul_a = 24'(nf_next);
      atgc_pkg::ST_TRIM2: mul_a = lenf_q - frl_q[23:0];
      default:            mul_a = lenf_q;
    endcase
  end
  assign mul_prod = 48'(mul_a) * 48'(atgc_pkg::TicksPerSec);

  atgc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dsr),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    exp_d     = exp_q;
    carry_d   = carry_q;
    started_d = started_q;
    period_d  = period_q;
    lenf_d    = lenf_q;
    chunkf_d  = chunkf_q;
    gap_d     = gap_q;
    frl_d     = frl_q;
    nf_d      = nf_q;
    cnt_d     = cnt_q;
    gb_d      = gb_q;
    nstart_d  = nstart_q;
    div_start = 1'b0;
    div_dvd   = 64'(mul_prod);
    div_dsr   = rate_eff;
    in_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o     = '0;
    unique case (state_q)
      atgc_pkg::ST_IDLE: begin
        if (!in_empty_i) begin
          in_pop_o  = 1'b1;
          item_d    = in_item_i;
          div_start = 1'b1;
          div_dvd   = 64'(atgc_pkg::TicksPerSec);
          state_d   = atgc_pkg::ST_PER;
        end
      end
      atgc_pkg::ST_PER: begin
        if (!div_busy) begin
          period_d  = div_quo[10:0];
          div_start = 1'b1;
          div_dvd   = 64'(item_q.length_bytes);
          div_dsr   = 19'(fb_eff);
          state_d   = atgc_pkg::ST_LEN;
        end
      end
      atgc_pkg::ST_LEN: begin
        if (!div_busy) begin
          lenf_d    = div_quo[23:0];
          div_start = 1'b1;
          div_dvd   = 64'(chunk_eff);
          div_dsr   = 19'(fb_eff);
          state_d   = atgc_pkg::ST_CHK;
        end
      end
      atgc_pkg::ST_CHK: begin
        if (!div_busy) begin
          chunkf_d = div_quo[20:0];
          state_d  = atgc_pkg::ST_CLASS;
        end
      end
      atgc_pkg::ST_CLASS: begin
        // first stamped packet anchors the timeline
        if (item_q.time_valid && !started_q) begin
          exp_d = start_sx;
        end
        gap_d = gap_raw + carry_sx;
        if (item_q.time_valid && started_q &&
            (mag_raw > 64'(cfg_i.gap_threshold))) begin
          state_d = atgc_pkg::ST_CORR;
        end else begin
          state_d = atgc_pkg::ST_PASS;
        end
      end
      atgc_pkg::ST_CORR: begin
        div_start = 1'b1;
        div_dvd   = mag_corr;
        div_dsr   = 19'(period_q);
        state_d   = atgc_pkg::ST_GAP;
      end
      atgc_pkg::ST_GAP: begin
        if (!div_busy) begin
          carry_d = gap_q[63] ? -$signed({1'b0, rem11}) : $signed({1'b0, rem11});
          frl_d   = (|div_quo[63:32]) ? '1 : div_quo[31:0];
          cnt_d   = '0;
          if (!gap_q[63] && (gap_q != '0)) begin
            state_d = atgc_pkg::ST_SIL;
          end else begin
            state_d = atgc_pkg::ST_TRIM;
          end
        end
      end
      atgc_pkg::ST_SIL: begin
        // stop on exhausted silence or at the chunk cap
        if ((frl_q == '0) || (cnt_q == CntW'(MaxSilenceChunks))) begin
          state_d = atgc_pkg::ST_PASS;
        end else begin
          nf_d      = nf_next;
          div_start = 1'b1;
          state_d   = atgc_pkg::ST_SILW;
        end
      end
      atgc_pkg::ST_SILW: begin
        if (!div_busy && !res_full_i) begin
          res_push_o       = 1'b1;
          res_o.kind       = atgc_pkg::KIND_SILENCE;
          res_o.out_start  = exp_q[62:0];
          res_o.out_bytes  = sil_prod[23:0];
          exp_d            = exp_q + div_quo;
          frl_d            = frl_q - 32'(nf_q);
          cnt_d            = cnt_q + CntW'(1);
          state_d          = atgc_pkg::ST_SIL;
        end
      end
      atgc_pkg::ST_PASS: begin
        div_start = 1'b1;
        state_d   = atgc_pkg::ST_PASSW;
      end
      atgc_pkg::ST_PASSW: begin
        if (!div_busy && !res_full_i) begin
          res_push_o      = 1'b1;
          res_o.kind      = atgc_pkg::KIND_PASS;
          res_o.out_start = item_q.start_time;
          res_o.out_bytes = item_q.length_bytes;
          res_o.last      = 1'b1;
          exp_d           = exp_q + div_quo;
          started_d       = 1'b1;
          state_d         = atgc_pkg::ST_IDLE;
        end
      end
      atgc_pkg::ST_TRIM: begin
        gb_d    = gb_prod;
        state_d = atgc_pkg::ST_TRIM2;
      end
      atgc_pkg::ST_TRIM2: begin
        if (gb_q >= 39'(item_q.length_bytes)) begin
          // trim covers the whole packet: drop it
          if (!res_full_i) begin
            res_push_o       = 1'b1;
            res_o.kind       = atgc_pkg::KIND_DROP;
            res_o.out_start  = item_q.start_time;
            res_o.skip_bytes = item_q.length_bytes;
            res_o.last       = 1'b1;
            state_d          = atgc_pkg::ST_IDLE;
          end
        end else begin
          nstart_d  = start_sx - gap_q;
          div_start = 1'b1;
          state_d   = atgc_pkg::ST_TRIMW;
        end
      end
      atgc_pkg::ST_TRIMW: begin
        if (!div_busy && !res_full_i) begin
          res_push_o       = 1'b1;
          res_o.kind       = atgc_pkg::KIND_TRIM;
          res_o.out_start  = nstart_q[62:0];
          res_o.out_stop   = nstop[62:0];
          res_o.out_bytes  = item_q.length_bytes - gb_q[23:0];
          res_o.skip_bytes = gb_q[23:0];
          res_o.last       = 1'b1;
          exp_d            = nstop;
          started_d        = 1'b1;
          state_d          = atgc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = atgc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= atgc_pkg::ST_IDLE;
      exp_q     <= '0;
      carry_q   <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      exp_q     <= exp_d;
      carry_q   <= carry_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    period_q <= period_d;
    lenf_q   <= lenf_d;
    chunkf_q <= chunkf_d;
    gap_q    <= gap_d;
    frl_q    <= frl_d;
    nf_q     <= nf_d;
    cnt_q    <= cnt_d;
    gb_q     <= gb_d;
    nstart_q <= nstart_d;
  end

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_div_not_restarted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == atgc_pkg::ST_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

  a_carry_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (carry_q <= atgc_pkg::MaxCarry) && (carry_q >= -atgc_pkg::MaxCarry))
    else $error("carry error exceeds one frame period");

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pop_o |=> (state_q == atgc_pkg::ST_PER) && div_busy)
    else $error("item taken without starting the period divide");

endmodule

>>> hw/rtl/audio_timestamp_gap_corrector_core.sv
// Work per packet: four 64-step divides (period, packet frames, chunk frames, duration) on the
// shared 1-bit/cycle divider from input transfer to a pass result.
// A corrected gap adds one divide and each silence chunk one more; a trim does its own
// duration divide in place of the pass one, and a drop does none.
// The engine takes packets one at a time; two-entry queues on both sides.
// Reset: config to 48000 Hz, 4-byte frames, 50000 threshold, 65536-byte chunks;
// timeline, carry and queues clear at once, no clearing pass.
module audio_timestamp_gap_corrector_core #(
  parameter int unsigned MAX_SILENCE_CHUNKS = 63
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [26:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic signed [62:0] start_time_i,
  input  logic               time_valid_i,
  input  logic [23:0]        length_bytes_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind_o,
  output logic signed [62:0] out_start_o,
  output logic signed [62:0] out_stop_o,
  output logic [23:0]        out_bytes_o,
  output logic [23:0]        skip_bytes_o,
  output logic               last_o
);

  atgc_pkg::cfg_t    cfg_q;
  atgc_pkg::item_t   in_item, eng_item;
  atgc_pkg::result_t eng_res, out_res;
  logic              in_empty, in_pop, res_full, res_push;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate   <= 19'd48000;
      cfg_q.frame_bytes   <= 7'd4;
      cfg_q.gap_threshold <= 27'd50000;
      cfg_q.chunk_bytes   <= 21'd65536;
    end else if (cfg_we_i) begin
      unique case (atgc_pkg::cfg_idx_e'(cfg_idx_i))
        atgc_pkg::CFG_SAMPLE_RATE:   cfg_q.sample_rate   <= cfg_wdata_i[18:0];
        atgc_pkg::CFG_FRAME_BYTES:   cfg_q.frame_bytes   <= cfg_wdata_i[6:0];
        atgc_pkg::CFG_GAP_THRESHOLD: cfg_q.gap_threshold <= cfg_wdata_i;
        atgc_pkg::CFG_CHUNK_BYTES:   cfg_q.chunk_bytes   <= cfg_wdata_i[20:0];
        default: ;
      endcase
    end
  end

  // front: take packet headers into the queue
  assign in_item.start_time   = start_time_i;
  assign in_item.time_valid   = time_valid_i;
  assign in_item.length_bytes = length_bytes_i;

  atgc_fifo #(
    .Width ($bits(atgc_pkg::item_t)),
    .Depth (2)
  ) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_item),
    .full_o  (full),
    .pop_i   (in_pop),
    .data_o  (eng_item),
    .empty_o (in_empty)
  );

  atgc_engine #(
    .MaxSilenceChunks (MAX_SILENCE_CHUNKS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_empty_i (in_empty),
    .in_pop_o   (in_pop),
    .in_item_i  (eng_item),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (eng_res)
  );

  // results wait here until transferred
  atgc_fifo #(
    .Width ($bits(atgc_pkg::result_t)),
    .Depth (2)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (eng_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign kind_o       = out_res.kind;
  assign out_start_o  = out_res.out_start;
  assign out_stop_o   = out_res.out_stop;
  assign out_bytes_o  = out_res.out_bytes;
  assign skip_bytes_o = out_res.skip_bytes;
  assign last_o       = out_res.last;

endmodule

>>> tb/sv/audio_timestamp_gap_corrector_core_tb.sv
// Self-checking testbench for audio_timestamp_gap_corrector_core.
// Depends on atgc_pkg; a timeline scoreboard predicts every result and
// compares each popped result against it.
module audio_timestamp_gap_corrector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxChunks = 63;
  localparam int unsigned IdleLimit = 30000;
  localparam int unsigned HoldCycles = 1500;
  localparam logic [63:0] Ticks = 64'd10000000;

  // Timeline scoreboard: own copy of config and state, queue of due results
  class timeline_sb;
    logic [atgc_pkg::RateW-1:0]  rate;
    logic [atgc_pkg::FrameW-1:0] frame;
    logic [atgc_pkg::ThrW-1:0]   threshold;
    logic [atgc_pkg::ChunkW-1:0] chunk;
    logic [63:0]                 expected;
    longint                      carry;
    bit                          started;
    logic [63:0]                 silence;
    atgc_pkg::result_t           due_q[$];
    int                          errors;

    function new();
      rate = 19'd48000;
      frame = 7'd4;
      threshold = 27'd50000;
      chunk = 21'd65536;
      expected = '0;
      carry = 0;
      started = 0;
      silence = '0;
      errors = 0;
    endfunction

    function void set_cfg(atgc_pkg::cfg_idx_e idx, logic [atgc_pkg::CfgW-1:0] data);
      case (idx)
        atgc_pkg::CFG_SAMPLE_RATE:   rate = data[atgc_pkg::RateW-1:0];
        atgc_pkg::CFG_FRAME_BYTES:   frame = data[atgc_pkg::FrameW-1:0];
        atgc_pkg::CFG_GAP_THRESHOLD: threshold = data[atgc_pkg::ThrW-1:0];
        atgc_pkg::CFG_CHUNK_BYTES:   chunk = data[atgc_pkg::ChunkW-1:0];
      endcase
    endfunction

    function logic [63:0] rate_eff();
      return (rate < 19'd8000) ? 64'd8000 : 64'(rate);
    endfunction

    function logic [63:0] frame_eff();
      return (frame == 0) ? 64'd1 : 64'(frame);
    endfunction

    function logic [63:0] chunk_eff();
      return (64'(chunk) < frame_eff()) ? frame_eff() : 64'(chunk);
    endfunction

    function logic [63:0] period();
      return Ticks / rate_eff();
    endfunction

    function logic [63:0] frames_time(logic [63:0] frames);
      return frames * Ticks / rate_eff();
    endfunction

    function void add(atgc_pkg::kind_e k, logic [63:0] st, logic [63:0] sp,
                      logic [63:0] nb, logic [63:0] sk, logic lst);
      atgc_pkg::result_t r;
      r.kind = k;
      r.out_start = st[atgc_pkg::TimeW-1:0];
      r.out_stop = sp[atgc_pkg::TimeW-1:0];
      r.out_bytes = nb[atgc_pkg::LenW-1:0];
      r.skip_bytes = sk[atgc_pkg::LenW-1:0];
      r.last = lst;
      due_q.push_back(r);
    endfunction

    // Advance the timeline for one accepted packet and queue its results
    function void note_input(atgc_pkg::item_t it);
      logic [63:0] st, gap, mag, frames, gbytes, rem, fbe, chk, per, b, d, len;
      logic [63:0] nlen, nstart, nstop;
      logic neg;
      int n;
      st = {it.start_time[atgc_pkg::TimeW-1], it.start_time};
      len = 64'(it.length_bytes);
      fbe = frame_eff();
      chk = chunk_eff();
      per = period();
      n = 0;
      if (it.time_valid) begin
        if (!started) expected = st;
        gap = st - expected;
        neg = gap[63];
        mag = neg ? -gap : gap;
        if (started && mag > 64'(threshold)) begin
          gap = gap + carry;
          neg = gap[63];
          mag = neg ? -gap : gap;
          frames = mag / per;
          rem = mag - frames * per;
          carry = neg ? -longint'(rem) : longint'(rem);
          gbytes = ((frames > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : frames) * fbe;
          if (!neg && gap != 0) begin
            // emit frame-aligned silence ahead of the late packet
            silence = expected;
            while (gbytes > 0 && n < MaxChunks) begin
              b = (gbytes < chk) ? gbytes : chk;
              b = b - b % fbe;
              if (b == 0) break;
              add(atgc_pkg::KIND_SILENCE, silence, 0, b, 0, 1'b0);
              n++;
              gbytes = gbytes - b;
              d = frames_time(b / fbe);
              expected = expected + d;
              silence = silence + d;
            end
          end else begin
            // early packet: drop whole or trim the front and retime
            if (gbytes >= len) begin
              add(atgc_pkg::KIND_DROP, st, 0, 0, len, 1'b1);
              return;
            end
            nlen = len - gbytes;
            nstart = st - gap;
            nstop = nstart + frames_time(nlen / fbe);
            expected = nstop;
            started = 1;
            add(atgc_pkg::KIND_TRIM, nstart, nstop, nlen, gbytes, 1'b1);
            return;
          end
        end
      end
      expected = expected + frames_time(len / fbe);
      started = 1;
      add(atgc_pkg::KIND_PASS, st, 0, len, 0, 1'b1);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(atgc_pkg::result_t got);
      atgc_pkg::result_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d start %0d", got.kind, got.out_start));
        return;
      end
      want = due_q.pop_front();
      if (got.kind != want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.out_start != want.out_start)
        report($sformatf("out_start %0h, want %0h", got.out_start, want.out_start));
      if (got.out_stop != want.out_stop)
        report($sformatf("out_stop %0h, want %0h", got.out_stop, want.out_stop));
      if (got.out_bytes != want.out_bytes)
        report($sformatf("out_bytes %0d, want %0d", got.out_bytes, want.out_bytes));
      if (got.skip_bytes != want.skip_bytes)
        report($sformatf("skip_bytes %0d, want %0d", got.skip_bytes, want.skip_bytes));
      if (got.last != want.last)
        report($sformatf("last %0d, want %0d", got.last, want.last));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [26:0]        cfg_wdata_i;
  logic               push;
  logic               full;
  logic signed [62:0] start_time_i;
  logic               time_valid_i;
  logic [23:0]        length_bytes_i;
  logic               empty;
  logic               pop;
  logic [1:0]         kind_o;
  logic signed [62:0] out_start_o;
  logic signed [62:0] out_stop_o;
  logic [23:0]        out_bytes_o;
  logic [23:0]        skip_bytes_o;
  logic               last_o;

  timeline_sb sb;
  bit idle_on;
  bit hold_req;
  int unsigned idle_cnt;
  int pop_burst;

  audio_timestamp_gap_corrector_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .push, .full, .start_time_i, .time_valid_i, .length_bytes_i,
    .empty, .pop, .kind_o, .out_start_o, .out_stop_o, .out_bytes_o,
    .skip_bytes_o, .last_o
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    atgc_pkg::result_t got;
    if (rst_ni && pop && !empty) begin
      got.kind = atgc_pkg::kind_e'(kind_o);
      got.out_start = out_start_o;
      got.out_stop = out_stop_o;
      got.out_bytes = out_bytes_o;
      got.skip_bytes = skip_bytes_o;
      got.last = last_o;
      sb.check_result(got);
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random pop pauses, plus one long hold-off on request
  initial begin
    pop = 1'b0;
    pop_burst = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 0;
      end
      if (idle_on && pop_burst == 0 && $urandom_range(0, 4) == 0)
        pop_burst = $urandom_range(1, 3);
      pop = (pop_burst == 0);
      if (pop_burst > 0) pop_burst--;
    end
  end

  task write_cfg(atgc_pkg::cfg_idx_e idx, logic [26:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_cfg(idx, data);
  endtask

  // Offer one packet and hold it until the transfer
  task send_packet(atgc_pkg::item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      push = 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk_i);
    end
    @(negedge clk_i);
    push = 1'b1;
    start_time_i = it.start_time;
    time_valid_i = it.time_valid;
    length_bytes_i = it.length_bytes;
    do @(posedge clk_i); while (full);
    sb.note_input(it);
  endtask

  // Wait for every due result, then let the block settle
  task drain();
    @(negedge clk_i);
    push = 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function atgc_pkg::item_t stamped(longint off, logic [23:0] len);
    atgc_pkg::item_t it;
    logic [63:0] st;
    st = sb.expected + off;
    it.start_time = st[62:0];
    it.time_valid = 1'b1;
    it.length_bytes = len;
    return it;
  endfunction

  function logic [31:0] capped(logic [63:0] v);
    return (v > 64'h3FFF_FFFF) ? 32'h3FFF_FFFF : v[31:0];
  endfunction

  // Mostly a continuous stream with jitter, late and early gaps; some noise
  function atgc_pkg::item_t random_packet();
    atgc_pkg::item_t it;
    logic [63:0] span, thr, fb;
    logic [23:0] len;
    int r;
    longint off;
    thr = 64'(sb.threshold);
    fb = sb.frame_eff();
    r = $urandom_range(0, 99);
    len = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
    if (r < 12) begin
      it.start_time = 63'({$urandom, $urandom});
      it.time_valid = 1'($urandom_range(0, 1));
      it.length_bytes = len;
      return it;
    end
    if (r < 50) begin
      off = longint'($urandom_range(0, thr[31:0]));
      if ($urandom_range(0, 1)) off = -off;
    end else if (r < 75) begin
      span = sb.period() * (sb.chunk_eff() / fb) * 3 + sb.period();
      off = longint'(thr) + 1 + longint'($urandom_range(0, capped(span)));
    end else begin
      span = sb.period() * (64'(len) / fb) * 2 + sb.period();
      off = -(longint'(thr) + 1 + longint'($urandom_range(0, capped(span))));
    end
    return stamped(off, len);
  endfunction

  task random_run(int count);
    repeat (count) send_packet(random_packet());
  endtask

  initial begin
    atgc_pkg::item_t it;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = atgc_pkg::CFG_SAMPLE_RATE;
    cfg_wdata_i = '0;
    push = 1'b0;
    start_time_i = '0;
    time_valid_i = 1'b0;
    length_bytes_i = '0;
    idle_on = 1;
    hold_req = 0;
    idle_cnt = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset config: unstamped first packet, field extremes, huge jumps
    it.start_time = 63'd12345;
    it.time_valid = 1'b0;
    it.length_bytes = 24'd400;
    send_packet(it);
    it.start_time = 63'h3FFF_FFFF_FFFF_FFFF;
    it.time_valid = 1'b1;
    it.length_bytes = 24'hFF_FFFF;
    send_packet(it);
    it.start_time = 63'h4000_0000_0000_0000;
    send_packet(it);
    send_packet(stamped(0, 24'd0));
    send_packet(stamped(50000 + 3 * 209, 24'd1000));
    send_packet(stamped(-60000, 24'd100000));
    random_run(20);
    drain();

    // Rate and frame below range, zero threshold, 64-byte chunk
    write_cfg(atgc_pkg::CFG_SAMPLE_RATE, 27'd0);
    write_cfg(atgc_pkg::CFG_FRAME_BYTES, 27'd0);
    write_cfg(atgc_pkg::CFG_GAP_THRESHOLD, 27'd0);
    write_cfg(atgc_pkg::CFG_CHUNK_BYTES, 27'd64);
    send_packet(stamped(0, 24'd50));
    send_packet(stamped(-1, 24'd0));
    send_packet(stamped(-1, 24'd100));
    send_packet(stamped(5, 24'd10));
    send_packet(stamped(1250 * 3 + 7, 24'd10));
    random_run(55);
    drain();

    // 384000 Hz rate, 64-byte frames, 100000000 threshold, 1048576-byte chunks
    write_cfg(atgc_pkg::CFG_SAMPLE_RATE, 27'd384000);
    write_cfg(atgc_pkg::CFG_FRAME_BYTES, 27'd64);
    write_cfg(atgc_pkg::CFG_GAP_THRESHOLD, 27'd100000000);
    write_cfg(atgc_pkg::CFG_CHUNK_BYTES, 27'd1048576);
    random_run(60);
    drain();

    // One frame per chunk: a long late gap hits the silence cap
    write_cfg(atgc_pkg::CFG_SAMPLE_RATE, 27'd8000);
    write_cfg(atgc_pkg::CFG_GAP_THRESHOLD, 27'd1000);
    write_cfg(atgc_pkg::CFG_CHUNK_BYTES, 27'd64);
    send_packet(stamped(0, 24'd640));
    send_packet(stamped(1250 * 200, 24'd640));
    random_run(40);
    drain();

    // Chunk below frame size, all-ones fields; receiver holds off
    write_cfg(atgc_pkg::CFG_SAMPLE_RATE, 27'h7FFFF);
    write_cfg(atgc_pkg::CFG_FRAME_BYTES, 27'h7F);
    write_cfg(atgc_pkg::CFG_GAP_THRESHOLD, 27'h7FF_FFFF);
    write_cfg(atgc_pkg::CFG_CHUNK_BYTES, 27'd64);
    hold_req = 1;
    random_run(60);
    drain();

    write_cfg(atgc_pkg::CFG_SAMPLE_RATE, 27'd44100);
    write_cfg(atgc_pkg::CFG_FRAME_BYTES, 27'd6);
    write_cfg(atgc_pkg::CFG_GAP_THRESHOLD, 27'd2000);
    write_cfg(atgc_pkg::CFG_CHUNK_BYTES, 27'h1F_FFFF);
    random_run(55);
    drain();

    // Last stretch at full rate on both sides
    idle_on = 0;
    random_run(55);
    drain();
    repeat (400) @(posedge clk_i);

    if (sb.due_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.due_q.size()));
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
